// File: rtl/ipl4_pkg.sv
// Package: shared types, constants and class codes of the IPv4 / L4 header parser.
`timescale 1ns / 1ps

package ipl4_pkg;

	localparam int OFFSET_WIDTH = 16;
	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] IP_MIN_BYTES = 16'd20;
	localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [3:0] IP_VERSION_4 = 4'd4;
	localparam logic [3:0] IP_MIN_WORDS = 4'd5;

	typedef enum logic [2:0] {
		CLS_RUNT     = 3'd0,
		CLS_NON_IPV4 = 3'd1,
		CLS_SHORT_IP = 3'd2,
		CLS_BAD_VER  = 3'd3,
		CLS_FRAGMENT = 3'd4,
		CLS_TCP      = 3'd5,
		CLS_UDP      = 3'd6,
		CLS_OTHER    = 3'd7
	} class_t;

	// Header fields captured while a frame streams through
	typedef struct packed {
		logic [15:0] eth_type;
		logic [7:0]  ver_hlen;
		logic [15:0] total_len;
		logic [15:0] frag;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] port_pair;
		logic [15:0] udp_len;
		logic [3:0]  tcp_off;
	} cap_t;

	// One frame request handed from the front to the back through the queue
	typedef struct packed {
		logic        runt;
		logic [15:0] wire_len;
		cap_t        cap;
		logic [31:0] frame_no;
	} rec_t;

	// Classified result
	typedef struct packed {
		class_t      cls;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] total_len;
		logic [3:0]  hdr_words;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] pay_len;
		logic        bad_hlen;
		logic        trunc;
		logic [31:0] frame_no;
	} res_t;

	function automatic logic [15:0] sat_sub16(input logic [15:0] a, input logic [15:0] b);
		sat_sub16 = (a > b) ? (a - b) : 16'd0;
	endfunction

endpackage

// File: rtl/ipv4_l4_header_parser.sv
// Top level: byte-serial Ethernet / IPv4 / TCP-UDP header parser.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   in      | input     | in_valid / in_stall   | data_byte, start/end_of_packet, wire_length
//   out     | output    | out_valid / out_stall | class_code ... packet_number
//
// Takes one byte per cycle while in_stall is low; one result per cycle can be
// sustained (one-byte frames) while out_stall is low. A result passes from its last
// byte into the 4-entry queue, then through the classifier into the output register.
// Reset clears offset, captures, packet count, queue pointers and output valid.
// in_stall is raised only while the request queue is full; a stalled result holds
// in the output register while the front keeps taking bytes until the queue fills.
`timescale 1ns / 1ps

module ipv4_l4_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_packet,
	input  logic        end_of_packet,
	input  logic [15:0] wire_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  class_code,
	output logic [7:0]  ip_protocol,
	output logic [31:0] source_address,
	output logic [31:0] destination_address,
	output logic [15:0] ip_total_length,
	output logic [3:0]  ip_header_words,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [15:0] payload_length,
	output logic        bad_header_length,
	output logic        truncated,
	output logic [31:0] packet_number
);

	logic           acc;
	logic           push;
	logic           full;
	logic           pop;
	logic           not_empty;
	ipl4_pkg::rec_t push_rec;
	ipl4_pkg::rec_t pop_rec;
	ipl4_pkg::res_t res;

	assign in_stall = full;
	assign acc = in_valid && !full;

	ipl4_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.acc             (acc),
		.data_byte       (data_byte),
		.start_of_packet (start_of_packet),
		.end_of_packet   (end_of_packet),
		.wire_length     (wire_length),
		.push            (push),
		.push_rec        (push_rec)
	);

	ipl4_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_rec   (pop_rec)
	);

	ipl4_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (not_empty),
		.rec       (pop_rec),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// Result fields to ports
	assign class_code = res.cls;
	assign ip_protocol = res.proto;
	assign source_address = res.src_ip;
	assign destination_address = res.dst_ip;
	assign ip_total_length = res.total_len;
	assign ip_header_words = res.hdr_words;
	assign source_port = res.src_port;
	assign destination_port = res.dst_port;
	assign payload_length = res.pay_len;
	assign bad_header_length = res.bad_hlen;
	assign truncated = res.trunc;
	assign packet_number = res.frame_no;

endmodule

// File: rtl/ipl4_front.sv
// Front end: byte offset tracking and header field capture, one byte per cycle when not stalled.
`timescale 1ns / 1ps

module ipl4_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [7:0]           data_byte,
	input  logic                 start_of_packet,
	input  logic                 end_of_packet,
	input  logic [15:0]          wire_length,
	output logic                 push,
	output ipl4_pkg::rec_t       push_rec
);

	logic [ipl4_pkg::OFFSET_WIDTH-1:0] offset_q;
	logic [15:0]                       wire_len_q;
	logic [31:0]                       pkt_cnt_q;
	ipl4_pkg::cap_t                    cap_q;

	logic [ipl4_pkg::OFFSET_WIDTH-1:0] off;
	logic [ipl4_pkg::OFFSET_WIDTH-1:0] off_nx;
	logic [ipl4_pkg::OFFSET_WIDTH-1:0] base;
	logic [ipl4_pkg::OFFSET_WIDTH-1:0] rel;
	logic [15:0]                       wire_len_nx;
	logic [31:0]                       pkt_cnt_nx;
	ipl4_pkg::cap_t                    cap_cur;
	ipl4_pkg::cap_t                    cap_nx;

	// Current offset and captures, restarted on a frame start; wire length loaded, packet count incremented
	always_comb begin
		off = start_of_packet ? '0 : offset_q;
		off_nx = (off == ipl4_pkg::OFFSET_MAX) ? off : off + 1'b1;
		cap_cur = start_of_packet ? '0 : cap_q;
		wire_len_nx = start_of_packet ? wire_length : wire_len_q;
		pkt_cnt_nx = start_of_packet ? pkt_cnt_q + 32'd1 : pkt_cnt_q;
	end

	// Fixed-offset Ethernet and IPv4 captures, then transport captures
	always_comb begin
		cap_nx = cap_cur;
		case (off)
			ipl4_pkg::OFFSET_WIDTH'(12): cap_nx.eth_type[15:8] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(13): cap_nx.eth_type[7:0] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(14): cap_nx.ver_hlen = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(16): cap_nx.total_len[15:8] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(17): cap_nx.total_len[7:0] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(20): cap_nx.frag[15:8] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(21): cap_nx.frag[7:0] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(23): cap_nx.proto = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(26): cap_nx.src_ip[31:24] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(27): cap_nx.src_ip[23:16] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(28): cap_nx.src_ip[15:8] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(29): cap_nx.src_ip[7:0] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(30): cap_nx.dst_ip[31:24] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(31): cap_nx.dst_ip[23:16] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(32): cap_nx.dst_ip[15:8] = data_byte;
			ipl4_pkg::OFFSET_WIDTH'(33): cap_nx.dst_ip[7:0] = data_byte;
			default: ;
		endcase

		// transport header starts after the IHL just captured (may overlap IP header)
		base = ipl4_pkg::OFFSET_WIDTH'(ipl4_pkg::ETH_HDR_BYTES)
			+ ipl4_pkg::OFFSET_WIDTH'({cap_nx.ver_hlen[3:0], 2'b00});
		rel = off - base;
		if (off >= base) begin
			case (rel)
				ipl4_pkg::OFFSET_WIDTH'(0):  cap_nx.port_pair[31:24] = data_byte;
				ipl4_pkg::OFFSET_WIDTH'(1):  cap_nx.port_pair[23:16] = data_byte;
				ipl4_pkg::OFFSET_WIDTH'(2):  cap_nx.port_pair[15:8] = data_byte;
				ipl4_pkg::OFFSET_WIDTH'(3):  cap_nx.port_pair[7:0] = data_byte;
				ipl4_pkg::OFFSET_WIDTH'(4):  cap_nx.udp_len[15:8] = data_byte;
				ipl4_pkg::OFFSET_WIDTH'(5):  cap_nx.udp_len[7:0] = data_byte;
				ipl4_pkg::OFFSET_WIDTH'(12): cap_nx.tcp_off = data_byte[7:4];
				default: ;
			endcase
		end
	end

	// Frame record pushed on the last byte
	always_comb begin
		push = acc && end_of_packet;
		push_rec.runt = (off < ipl4_pkg::OFFSET_WIDTH'(13));
		push_rec.wire_len = wire_len_nx;
		push_rec.cap = cap_nx;
		push_rec.frame_no = pkt_cnt_nx;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			wire_len_q <= '0;
			pkt_cnt_q <= '0;
			cap_q <= '0;
		end else if (acc) begin
			offset_q <= off_nx;
			wire_len_q <= wire_len_nx;
			pkt_cnt_q <= pkt_cnt_nx;
			cap_q <= cap_nx;
		end
	end

	a_off_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !start_of_packet && offset_q != ipl4_pkg::OFFSET_MAX
		|=> offset_q == $past(offset_q) + 1'b1)
		else $error("offset did not advance on a continuing byte");

	a_off_sop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && start_of_packet |=> offset_q == ipl4_pkg::OFFSET_WIDTH'(1))
		else $error("offset not restarted on frame start");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !start_of_packet |=> pkt_cnt_q == $past(pkt_cnt_q))
		else $error("packet count moved without a frame start");

endmodule

// File: rtl/ipl4_fifo.sv
// Short request queue between the capture front end and the classifier.
`timescale 1ns / 1ps

module ipl4_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ipl4_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output ipl4_pkg::rec_t pop_rec
);

	ipl4_pkg::rec_t                  entry_q [ipl4_pkg::QUEUE_DEPTH];
	logic [ipl4_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [ipl4_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [ipl4_pkg::QUEUE_AW:0]     count_q;

	assign full = (count_q == (ipl4_pkg::QUEUE_AW+1)'(ipl4_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_rec = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && not_empty})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (ipl4_pkg::QUEUE_AW+1)'(ipl4_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

endmodule

// File: rtl/ipl4_back.sv
// Back end: frame classification and registered result output.
`timescale 1ns / 1ps

module ipl4_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	input  ipl4_pkg::rec_t rec,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output ipl4_pkg::res_t res
);

	logic           out_valid_q;
	ipl4_pkg::res_t res_q;
	ipl4_pkg::res_t res_nx;

	logic [15:0] ip_avail;
	logic [15:0] after_ip;
	logic [3:0]  hwords;

	assign pop = rec_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res = res_q;

	// Classification and length arithmetic
	always_comb begin
		hwords = rec.cap.ver_hlen[3:0];
		ip_avail = ipl4_pkg::sat_sub16(rec.wire_len, ipl4_pkg::ETH_HDR_BYTES);
		after_ip = ipl4_pkg::sat_sub16(rec.cap.total_len, {10'd0, hwords, 2'b00});
		res_nx = '0;
		res_nx.frame_no = rec.frame_no;
		if (rec.runt) begin
			res_nx.cls = ipl4_pkg::CLS_RUNT;
		end else if (rec.cap.eth_type != ipl4_pkg::ETHERTYPE_IPV4) begin
			res_nx.cls = ipl4_pkg::CLS_NON_IPV4;
		end else if (ip_avail < ipl4_pkg::IP_MIN_BYTES) begin
			res_nx.cls = ipl4_pkg::CLS_SHORT_IP;
		end else begin
			res_nx.proto = rec.cap.proto;
			res_nx.src_ip = rec.cap.src_ip;
			res_nx.dst_ip = rec.cap.dst_ip;
			res_nx.total_len = rec.cap.total_len;
			res_nx.hdr_words = hwords;
			if (rec.cap.ver_hlen[7:4] != ipl4_pkg::IP_VERSION_4) begin
				res_nx.cls = ipl4_pkg::CLS_BAD_VER;
			end else begin
				res_nx.bad_hlen = (hwords < ipl4_pkg::IP_MIN_WORDS);
				res_nx.trunc = (ip_avail < rec.cap.total_len);
				if ((rec.cap.frag & ipl4_pkg::FRAG_OFFSET_MASK) != '0) begin
					res_nx.cls = ipl4_pkg::CLS_FRAGMENT;
				end else if (rec.cap.proto == ipl4_pkg::PROTO_TCP) begin
					res_nx.cls = ipl4_pkg::CLS_TCP;
					res_nx.src_port = rec.cap.port_pair[31:16];
					res_nx.dst_port = rec.cap.port_pair[15:0];
					res_nx.pay_len = ipl4_pkg::sat_sub16(after_ip,
						{10'd0, rec.cap.tcp_off, 2'b00});
				end else if (rec.cap.proto == ipl4_pkg::PROTO_UDP) begin
					res_nx.cls = ipl4_pkg::CLS_UDP;
					res_nx.src_port = rec.cap.port_pair[31:16];
					res_nx.dst_port = rec.cap.port_pair[15:0];
					res_nx.pay_len = ipl4_pkg::sat_sub16(rec.cap.udp_len,
						ipl4_pkg::UDP_HDR_BYTES);
				end else begin
					res_nx.cls = ipl4_pkg::CLS_OTHER;
				end
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_nx;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_ports_l4: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.cls != ipl4_pkg::CLS_TCP && res_q.cls != ipl4_pkg::CLS_UDP
		|-> res_q.src_port == '0 && res_q.dst_port == '0 && res_q.pay_len == '0)
		else $error("transport fields set on a non TCP/UDP result");

	a_flags_v4: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.bad_hlen || res_q.trunc)
		|-> res_q.cls != ipl4_pkg::CLS_RUNT && res_q.cls != ipl4_pkg::CLS_NON_IPV4
		&& res_q.cls != ipl4_pkg::CLS_SHORT_IP && res_q.cls != ipl4_pkg::CLS_BAD_VER)
		else $error("header flags set before IPv4 version check");

	a_pop_space: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rec_valid)
		else $error("pop without a queued request");

endmodule
